/* src/aesd_pkg.sv */
`timescale 1ns / 1ps
// Package for the AES-128 decryption block: payload and command types, S-box
// tables and GF(2^8) helper functions. Depends on nothing.
package aesd_pkg;

  typedef struct packed {
    logic [63:0] cipher_high;
    logic [63:0] cipher_low;
  } in_item_t;

  typedef struct packed {
    logic [63:0] plain_high;
    logic [63:0] plain_low;
  } out_item_t;

  localparam int unsigned NUM_ROUNDS = 10;

  localparam logic [0:0] REG_KEY_LOW  = 1'b0;
  localparam logic [0:0] REG_KEY_HIGH = 1'b1;

  typedef struct packed {
    logic load_state;
    logic run_round;
    logic last_round;
    logic load_key;
    logic exp_step;
    logic [3:0] round;
  } dp_cmd_t;

  typedef struct packed {
    logic key_ready;
  } dp_stat_t;

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [3:0] b);
    logic [7:0] p;
    logic [7:0] x;
    p = 8'h00;
    x = a;
    for (int i = 0; i < 4; i++) begin
      if (b[i]) p = p ^ x;
      x = xtime(x);
    end
    gmul = p;
  endfunction

  function automatic logic [7:0] ginv(input logic [7:0] a);
    logic [7:0] r;
    logic [7:0] x;
    logic [7:0] p;
    logic [7:0] y;
    r = 8'h01;
    x = a;
    for (int i = 0; i < 7; i++) begin
      p = 8'h00;
      y = x;
      for (int j = 0; j < 8; j++) begin
        if (x[j]) p = p ^ y;
        y = xtime(y);
      end
      x = p;
      p = 8'h00;
      y = r;
      for (int j = 0; j < 8; j++) begin
        if (x[j]) p = p ^ y;
        y = xtime(y);
      end
      r = p;
    end
    ginv = r;
  endfunction

  function automatic logic [7:0] rotl8(input logic [7:0] a, input int n);
    rotl8 = (a << n) | (a >> (8 - n));
  endfunction

  function automatic logic [7:0] sbox_calc(input logic [7:0] a);
    logic [7:0] b;
    b = ginv(a);
    sbox_calc = b ^ rotl8(b, 1) ^ rotl8(b, 2) ^ rotl8(b, 3) ^ rotl8(b, 4) ^ 8'h63;
  endfunction

  function automatic logic [7:0] inv_sbox_calc(input logic [7:0] a);
    inv_sbox_calc = ginv(rotl8(a, 1) ^ rotl8(a, 3) ^ rotl8(a, 6) ^ 8'h05);
  endfunction

  typedef logic [7:0] sbox_t [256];

  function automatic sbox_t build_sbox(input logic inv);
    sbox_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = inv ? inv_sbox_calc(8'(i)) : sbox_calc(8'(i));
    end
    build_sbox = t;
  endfunction

  localparam sbox_t SBOX     = build_sbox(1'b0);
  localparam sbox_t INV_SBOX = build_sbox(1'b1);

  function automatic logic [127:0] inv_mix(input logic [127:0] s);
    logic [127:0] o;
    logic [7:0] a0, a1, a2, a3;
    o = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = s[32*c +: 8];
      a1 = s[32*c+8 +: 8];
      a2 = s[32*c+16 +: 8];
      a3 = s[32*c+24 +: 8];
      o[32*c +: 8]    = gmul(a0, 4'd14) ^ gmul(a1, 4'd11) ^ gmul(a2, 4'd13) ^ gmul(a3, 4'd9);
      o[32*c+8 +: 8]  = gmul(a0, 4'd9) ^ gmul(a1, 4'd14) ^ gmul(a2, 4'd11) ^ gmul(a3, 4'd13);
      o[32*c+16 +: 8] = gmul(a0, 4'd13) ^ gmul(a1, 4'd9) ^ gmul(a2, 4'd14) ^ gmul(a3, 4'd11);
      o[32*c+24 +: 8] = gmul(a0, 4'd11) ^ gmul(a1, 4'd13) ^ gmul(a2, 4'd9) ^ gmul(a3, 4'd14);
    end
    inv_mix = o;
  endfunction

  function automatic logic [127:0] inv_shift_sub(input logic [127:0] s);
    logic [127:0] t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[8*(4*((c + r) % 4) + r) +: 8] = INV_SBOX[s[8*(4*c + r) +: 8]];
      end
    end
    inv_shift_sub = t;
  endfunction

  function automatic logic [127:0] next_round_key(input logic [127:0] k,
                                                  input logic [7:0] rcon);
    logic [127:0] n;
    logic [31:0] t;
    t = {SBOX[k[103:96]], SBOX[k[127:120]], SBOX[k[119:112]],
         SBOX[k[111:104]] ^ rcon};
    n[31:0]   = k[31:0] ^ t;
    n[63:32]  = k[63:32] ^ n[31:0];
    n[95:64]  = k[95:64] ^ n[63:32];
    n[127:96] = k[127:96] ^ n[95:64];
    next_round_key = n;
  endfunction

endpackage

/* src/aesd_ram.sv */
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module aesd_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

/* src/aesd_datapath.sv */
`timescale 1ns / 1ps
// Datapath: state register, round logic, key expansion and key store.
// Depends on aesd_pkg and aesd_ram.
module aesd_datapath
  import aesd_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  dp_cmd_t        cmd,
  input  in_item_t       in_data,
  input  logic [127:0]   key,
  output dp_stat_t       stat,
  output out_item_t      result
);

  logic [127:0] state_r, state_nxt;
  logic [127:0] ekey_r, ekey_nxt;
  logic [7:0]   rcon_r, rcon_nxt;
  logic [3:0]   waddr_r, waddr_nxt;
  logic         ready_r, ready_nxt;
  logic [3:0]   key_raddr;
  logic [127:0] rk;
  logic [127:0] wdata;
  logic [127:0] after_sub;

  // Entry 0..10 holds key r, already InvMixColumns-transformed for rounds 1 to 9.
  assign key_raddr = cmd.round;
  assign wdata = (waddr_r == 4'd0 || waddr_r == 4'(NUM_ROUNDS)) ? ekey_r : inv_mix(ekey_r);

  aesd_ram #(.WIDTH(128), .DEPTH(16)) u_keys (
    .clk  (clk),
    .we   (cmd.exp_step),
    .waddr(waddr_r),
    .wdata(wdata),
    .raddr(key_raddr),
    .rdata(rk)
  );

  assign after_sub = inv_shift_sub(state_r);

  always_comb begin
    state_nxt = state_r;
    if (cmd.load_state) begin
      state_nxt = {in_data.cipher_high, in_data.cipher_low};
    end else if (cmd.run_round) begin
      if (cmd.round == 4'(NUM_ROUNDS)) state_nxt = state_r ^ rk;
      else if (cmd.last_round) state_nxt = after_sub ^ rk;
      else state_nxt = inv_mix(after_sub) ^ rk;
    end
    ekey_nxt  = ekey_r;
    rcon_nxt  = rcon_r;
    waddr_nxt = waddr_r;
    ready_nxt = ready_r;
    if (cmd.load_key) begin
      ekey_nxt  = key;
      rcon_nxt  = 8'h01;
      waddr_nxt = '0;
      ready_nxt = 1'b0;
    end else if (cmd.exp_step) begin
      ekey_nxt  = next_round_key(ekey_r, rcon_r);
      rcon_nxt  = xtime(rcon_r);
      waddr_nxt = waddr_r + 4'd1;
      if (waddr_r == 4'(NUM_ROUNDS)) ready_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    state_r <= state_nxt;
    ekey_r  <= ekey_nxt;
    rcon_r  <= rcon_nxt;
    if (!rst_n) begin
      waddr_r <= '0;
      ready_r <= 1'b1;
    end else begin
      waddr_r <= waddr_nxt;
      ready_r <= ready_nxt;
    end
  end

  assign stat.key_ready = ready_r;
  assign result.plain_low  = state_r[63:0];
  assign result.plain_high = state_r[127:64];

endmodule

/* src/aesd_ctrl.sv */
`timescale 1ns / 1ps
// Controller state machine: sequences key expansion, rounds and result hand-off.
// Depends on aesd_pkg.
module aesd_ctrl
  import aesd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     key_write,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_EXPAND = 5'b00010,
    ST_FETCH  = 5'b00100,
    ST_ROUND  = 5'b01000,
    ST_OUT    = 5'b10000
  } state_t;

  state_t     st_r, st_nxt;
  logic [3:0] round_r, round_nxt;
  logic       pend_r, pend_nxt;

  assign in_ready  = (st_r == ST_IDLE) && !pend_r && !key_write;
  assign out_valid = (st_r == ST_OUT);

  always_comb begin
    st_nxt    = st_r;
    round_nxt = round_r;
    pend_nxt  = pend_r || key_write;
    cmd       = '0;
    cmd.round = round_r;
    unique case (st_r)
      ST_IDLE: begin
        if (pend_r) begin
          cmd.load_key = 1'b1;
          pend_nxt     = key_write;
          st_nxt       = ST_EXPAND;
        end else if (in_valid && !key_write) begin
          cmd.load_state = 1'b1;
          round_nxt      = 4'(NUM_ROUNDS);
          st_nxt         = ST_FETCH;
        end
      end
      ST_EXPAND: begin
        cmd.exp_step = 1'b1;
        if (cmd.exp_step && stat.key_ready) st_nxt = ST_IDLE;
        if (round_r == 4'(NUM_ROUNDS)) st_nxt = ST_IDLE;
        round_nxt = (round_r == 4'(NUM_ROUNDS)) ? 4'd0 : round_r + 4'd1;
      end
      ST_FETCH: begin
        st_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        cmd.run_round  = 1'b1;
        cmd.last_round = (round_r == 4'd0);
        if (round_r == 4'd0) begin
          st_nxt = ST_OUT;
        end else begin
          round_nxt = round_r - 4'd1;
          st_nxt    = ST_FETCH;
        end
      end
      ST_OUT: begin
        if (out_ready) begin
          st_nxt    = ST_IDLE;
          round_nxt = 4'd0;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_IDLE;
      round_r <= 4'd0;
      pend_r  <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      round_r <= round_nxt;
      pend_r  <= pend_nxt;
    end
  end

endmodule

/* src/aes128_block_decrypt.sv */
`timescale 1ns / 1ps
// AES-128 ECB block decryption using the equivalent inverse cipher.
// Depends on aesd_pkg, aesd_ctrl, aesd_datapath and aesd_ram.
//
// The key is written through the cfg_ APB port: key_low at byte address 0 and
// key_high at 8, 64-bit data. Each key write starts an expansion, a key load
// followed by the steps for the eleven round keys, which fills a round key
// memory one key a cycle; the input channel is held off until it completes.
// A request on the in_ channel carries one ciphertext block; the plaintext
// then stands on the out_ channel. Each of the eleven key additions has
// a FETCH state, which reads the round key from the registered memory port,
// and a ROUND state, which passes the block through the round logic. A new
// block is accepted only after the last result has been handed off; one block
// is in flight at a time. If the receiver stalls, the result is held and no
// new request is accepted.
// Synchronous reset clears the key registers to zero and the control state;
// a key must be written before the first block, as the key memory is not
// cleared.
module aes128_block_decrypt
  import aesd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [63:0] key_low_r, key_high_r;
  logic        wr;
  logic        write_lo, write_hi, key_wr_any;
  dp_cmd_t     cmd;
  dp_stat_t    stat;

  assign cfg_pready = 1'b1;
  assign wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[3] == REG_KEY_HIGH) ? key_high_r : key_low_r;

  assign write_lo = wr && (cfg_paddr[3] == REG_KEY_LOW);
  assign write_hi = wr && (cfg_paddr[3] == REG_KEY_HIGH);
  assign key_wr_any = write_lo || write_hi;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r  <= '0;
      key_high_r <= '0;
    end else begin
      if (write_lo) key_low_r <= cfg_pwdata;
      if (write_hi) key_high_r <= cfg_pwdata;
    end
  end

  aesd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .key_write(key_wr_any),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  aesd_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .key      ({key_high_r, key_low_r}),
    .stat     (stat),
    .result   (out_data)
  );

endmodule

/* dv/aesd_checker.sv */
`timescale 1ns / 1ps
// Checker for the AES-128 decryption block: watches the key port and both
// request channels, predicts each plaintext and compares. Depends on aesd_pkg.
module aesd_checker
  import aesd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_item_t    in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_item_t   out_data,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          fail_count,
  output int          pending_count
);

  logic [63:0]  key_lo_q, key_hi_q;
  logic [127:0] round_keys [11];
  logic [127:0] dec_keys [11];
  out_item_t    plain_q [$];

  function automatic logic [7:0] gf_xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = gf_xt(a);
    end
    return p;
  endfunction

  function automatic logic [7:0] gf_inv(input logic [7:0] a);
    logic [7:0] r;
    r = 8'h01;
    for (int i = 0; i < 7; i++) begin
      a = gf_mul(a, a);
      r = gf_mul(r, a);
    end
    return r;
  endfunction

  function automatic logic [7:0] rol(input logic [7:0] a, input int n);
    return (a << n) | (a >> (8 - n));
  endfunction

  function automatic logic [7:0] fwd_sub(input logic [7:0] a);
    logic [7:0] b;
    b = gf_inv(a);
    return b ^ rol(b, 1) ^ rol(b, 2) ^ rol(b, 3) ^ rol(b, 4) ^ 8'h63;
  endfunction

  function automatic logic [7:0] rev_sub(input logic [7:0] a);
    return gf_inv(rol(a, 1) ^ rol(a, 3) ^ rol(a, 6) ^ 8'h05);
  endfunction

  function automatic logic [127:0] unmix(input logic [127:0] s);
    logic [127:0] o;
    logic [7:0] b0, b1, b2, b3;
    for (int c = 0; c < 4; c++) begin
      b0 = s[32*c +: 8];
      b1 = s[32*c+8 +: 8];
      b2 = s[32*c+16 +: 8];
      b3 = s[32*c+24 +: 8];
      o[32*c +: 8]    = gf_mul(b0, 8'd14) ^ gf_mul(b1, 8'd11) ^ gf_mul(b2, 8'd13) ^
                        gf_mul(b3, 8'd9);
      o[32*c+8 +: 8]  = gf_mul(b0, 8'd9) ^ gf_mul(b1, 8'd14) ^ gf_mul(b2, 8'd11) ^
                        gf_mul(b3, 8'd13);
      o[32*c+16 +: 8] = gf_mul(b0, 8'd13) ^ gf_mul(b1, 8'd9) ^ gf_mul(b2, 8'd14) ^
                        gf_mul(b3, 8'd11);
      o[32*c+24 +: 8] = gf_mul(b0, 8'd11) ^ gf_mul(b1, 8'd13) ^ gf_mul(b2, 8'd9) ^
                        gf_mul(b3, 8'd14);
    end
    return o;
  endfunction

  function automatic logic [127:0] unshift_unsub(input logic [127:0] s);
    logic [127:0] t;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        t[8*(4*((c + r) % 4) + r) +: 8] = rev_sub(s[8*(4*c + r) +: 8]);
    return t;
  endfunction

  function automatic void expand_schedule();
    logic [7:0] w [176];
    logic [7:0] t0, t1, t2, t3, u, rc;
    rc = 8'h01;
    for (int i = 0; i < 8; i++) begin
      w[i] = key_lo_q[8*i +: 8];
      w[i+8] = key_hi_q[8*i +: 8];
    end
    for (int i = 16; i < 176; i += 4) begin
      t0 = w[i-4]; t1 = w[i-3]; t2 = w[i-2]; t3 = w[i-1];
      if (i % 16 == 0) begin
        u = t0;
        t0 = fwd_sub(t1) ^ rc;
        t1 = fwd_sub(t2);
        t2 = fwd_sub(t3);
        t3 = fwd_sub(u);
        rc = gf_xt(rc);
      end
      w[i] = w[i-16] ^ t0;
      w[i+1] = w[i-15] ^ t1;
      w[i+2] = w[i-14] ^ t2;
      w[i+3] = w[i-13] ^ t3;
    end
    for (int r = 0; r < 11; r++) begin
      for (int b = 0; b < 16; b++) round_keys[r][8*b +: 8] = w[16*r + b];
      dec_keys[r] = unmix(round_keys[r]);
    end
  endfunction

  function automatic out_item_t decrypt_block(input in_item_t c);
    logic [127:0] s;
    out_item_t p;
    s = {c.cipher_high, c.cipher_low} ^ round_keys[10];
    for (int r = 9; r >= 1; r--) s = unmix(unshift_unsub(s)) ^ dec_keys[r];
    s = unshift_unsub(s) ^ round_keys[0];
    p.plain_high = s[127:64];
    p.plain_low = s[63:0];
    return p;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending_count = 0;
    key_lo_q = '0;
    key_hi_q = '0;
  end

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      key_lo_q = '0;
      key_hi_q = '0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        if (cfg_paddr[3]) key_hi_q = cfg_pwdata;
        else key_lo_q = cfg_pwdata;
        expand_schedule();
      end
      if (in_valid && in_ready) plain_q.push_back(decrypt_block(in_data));
      if (out_valid && out_ready) begin
        if (plain_q.size() == 0) begin
          report_mismatch("unexpected result", out_data.plain_low, '0);
        end else begin
          want = plain_q.pop_front();
          if (out_data.plain_low !== want.plain_low)
            report_mismatch("plain_low", out_data.plain_low, want.plain_low);
          if (out_data.plain_high !== want.plain_high)
            report_mismatch("plain_high", out_data.plain_high, want.plain_high);
        end
      end
    end
    pending_count = plain_q.size();
  end

endmodule

/* dv/tb_aes128_block_decrypt.sv */
`timescale 1ns / 1ps
// Top of the AES-128 decryption testbench: drives keys and ciphertext
// requests with random gaps and stalls. Depends on aesd_pkg, aesd_checker and aes128_block_decrypt.
module tb_aes128_block_decrypt;
  import aesd_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid, in_ready, out_valid, out_ready;
  in_item_t    in_data;
  out_item_t   out_data;
  logic        cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [3:0]  cfg_paddr;
  logic [63:0] cfg_pwdata, cfg_prdata;
  int          fail_count, pending_count;
  int          stall_mode;

  aes128_block_decrypt uut (.*);
  aesd_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #60ms;
    $display("Regression FAIL");
    $finish;
  end

  // The receiver alternates between free flow, light and heavy stalling.
  always @(posedge clk) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      default: out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  task automatic write_key(input logic [3:0] addr, input logic [63:0] value);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_block(input logic [63:0] lo, input logic [63:0] hi);
    in_valid <= 1'b1;
    in_data <= '{cipher_high: hi, cipher_low: lo};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] pick_field();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return rand64();
    endcase
  endfunction

  task automatic random_blocks(input int count);
    int burst;
    while (count > 0) begin
      burst = $urandom_range(1, 12);
      while (burst > 0 && count > 0) begin
        send_block(pick_field(), pick_field());
        burst--;
        count--;
      end
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b1;
    stall_mode = 0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Standard test key with one further ciphertext, plus the field extremes.
    write_key(4'd0, 64'h0706050403020100);
    write_key(4'd8, 64'h0f0e0d0c0b0a0908);
    send_block(64'hd8cd7b7004c0b430, 64'h5ac5b47080b7cdd8);
    send_block('0, '0);
    send_block('1, '1);
    send_block('0, '1);
    send_block(64'h8000000000000000, 64'h0000000000000001);
    in_valid <= 1'b0;
    drain();

    // Partial updates of each half of the key.
    write_key(4'd0, '1);
    send_block('0, '1);
    send_block(64'h0123456789abcdef, 64'hfedcba9876543210);
    in_valid <= 1'b0;
    drain();
    write_key(4'd8, '1);
    send_block('1, '0);
    send_block('1, '1);
    in_valid <= 1'b0;
    drain();
    write_key(4'd0, '0);
    write_key(4'd8, '0);
    send_block('0, '0);
    send_block(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
    in_valid <= 1'b0;
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      if ($urandom_range(0, 1) != 0) write_key(4'd0, pick_field());
      write_key(4'd8, pick_field());
      if ($urandom_range(0, 3) == 0) write_key(4'd0, pick_field());
      random_blocks(160);
      drain();
    end

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
